### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the triangulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an expression holds at every rising clock edge outside reset.
`define ECT_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("invariant violated");
// Checks that a consequent holds in the same cycle as its antecedent.
`define ECT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication violated");
`endif

### hw/rtl/ect_pkg.sv
// Package with constants, codes and types of the ear clipping triangulator.
`default_nettype none
package ect_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;
	localparam int AW           = $clog2(MAX_VERTICES);
	localparam int CNT_W        = AW + 1;
	localparam int DIFF_W       = COORD_BITS + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int EV_W         = PROD_W + 1;
	localparam int SUM_W        = EV_W + AW;

	localparam logic [1:0] CLS_COLLINEAR = 2'd0;
	localparam logic [1:0] CLS_CONVEX    = 2'd1;
	localparam logic [1:0] CLS_REFLEX    = 2'd2;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_FEW  = 2'd1;
	localparam logic [1:0] ERR_MANY = 2'd2;

	typedef enum logic [2:0] {
		OP_SHO, OP_TRI, OP_D1, OP_D2, OP_D3
	} op_t;

	typedef enum logic [5:0] {
		S_IN, S_L0, S_L1, S_L2, S_EV,
		S_SH0, S_SH1, S_SH2, S_SH3, S_IW,
		S_CL0, S_CL1, S_CL2, S_CL3, S_CL4,
		S_PK0, S_PK1, S_PK2, S_PK3, S_PK4,
		S_KK0, S_KK1, S_KK2, S_KK3, S_KK4, S_KK5,
		S_FB, S_EM0, S_EM1, S_EM2, S_EM3,
		S_SF0, S_SF1, S_FIN0, S_FIN1, S_FIN2, S_FIN3, S_OUT
	} state_t;

	// Ring neighbors of a list position in a list of length n.
	function automatic logic [CNT_W-1:0] pos_prev(input logic [CNT_W-1:0] p,
			input logic [CNT_W-1:0] n);
		return (p == '0) ? n - CNT_W'(1) : p - CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] pos_next(input logic [CNT_W-1:0] p,
			input logic [CNT_W-1:0] n);
		return (p == n - CNT_W'(1)) ? '0 : p + CNT_W'(1);
	endfunction
endpackage
`default_nettype wire

### hw/rtl/ear_clip_polygon_triangulator.sv
// Top level of the ear clipping polygon triangulator: sequencer, memories and datapath.
// Vertex requests are taken while the block waits for input; only the last one starts the work.
// Triangulation computes the orientation sum, writes the list, runs a classification
// pass and searches for an ear, testing each candidate against the other vertices,
// all paced by the single read port of the coordinate memory and the pipelined cross unit.
// Throughput: one polygon at a time; no request is taken while results are produced.
// Reset clears the sequencer and counters at once; the memories are not cleared.
`default_nettype none
`include "assert_macros.svh"
module ear_clip_polygon_triangulator import ect_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] x_coord,
	input  wire logic signed [COORD_BITS-1:0] y_coord,
	input  wire logic                         last_vertex,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [AW-1:0]                     first_index,
	output logic [AW-1:0]                     middle_index,
	output logic [AW-1:0]                     third_index,
	output logic                              last_triangle,
	output logic [1:0]                        error_code
);
	// Memories: coordinates by original index, the remaining-vertex list and
	// the class of each list position. All reads are registered.
	logic [2*COORD_BITS-1:0] coord_mem [MAX_VERTICES];
	logic [AW-1:0]           list_mem  [MAX_VERTICES];
	logic [1:0]              class_mem [MAX_VERTICES];

	logic                    cm_we, lm_we, km_we;
	logic [AW-1:0]           cm_wa, cm_ra, lm_wa, lm_ra, km_wa, km_ra;
	logic [2*COORD_BITS-1:0] cm_wd, cm_rd_q;
	logic [AW-1:0]           lm_wd, lm_rd_q;
	logic [1:0]              km_wd, km_rd_q;

	always_ff @(posedge clk) begin
		if (cm_we) coord_mem[cm_wa] <= cm_wd;
		cm_rd_q <= coord_mem[cm_ra];
	end

	always_ff @(posedge clk) begin
		if (lm_we) list_mem[lm_wa] <= lm_wd;
		lm_rd_q <= list_mem[lm_ra];
	end

	always_ff @(posedge clk) begin
		if (km_we) class_mem[km_wa] <= km_wd;
		km_rd_q <= class_mem[km_ra];
	end

	// Sequencer state and counters.
	state_t             state_q, state_d, ld_ret_q, ld_ret_d, ev_ret_q, ev_ret_d;
	state_t             out_ret_q, out_ret_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d, n_q, n_d, i_q, i_d, k_q, k_d;
	logic [CNT_W-1:0]   ear_q, ear_d, fnr_q, fnr_d, ld_pos_q, ld_pos_d;
	logic               ovf_q, ovf_d, fnr_v_q, fnr_v_d, ld_dir_q, ld_dir_d;
	logic               neg_q, neg_d, pos_q, pos_d, call_ld, call_ev;
	logic [1:0]         ld_slot_q, ld_slot_d, ev_cnt_q, ev_cnt_d;
	op_t                op_q, op_d;
	logic signed [SUM_W-1:0] s_q, s_d;
	logic [AW-1:0]      first_q, first_d, middle_q, middle_d, third_q, third_d;
	logic               last_q, last_d;
	logic [1:0]         err_q, err_d;

	// Loaded vertices: slots 0..2 hold a triangle, slot 3 the test point.
	logic signed [COORD_BITS-1:0] sx_q [4];
	logic signed [COORD_BITS-1:0] sy_q [4];
	logic [AW-1:0]                tid_q [4];

	// Cross unit: three stages from operands to the edge value.
	logic signed [COORD_BITS-1:0] ax, ay, bx, by, qx, qy;
	logic signed [DIFF_W-1:0]     bax_s1, qay_s1, bay_s1, qax_s1;
	logic signed [PROD_W-1:0]     m1_s2, m2_s2;
	logic signed [EV_W-1:0]       ev_s3;
	logic                         ev_neg, ev_pos, neg_f, pos_f, room;
	logic [CNT_W-1:0]             prev_i, next_i, prev_e, next_e, rev_pos, n_new;

	assign prev_i  = pos_prev(i_q, n_q);
	assign next_i  = pos_next(i_q, n_q);
	assign prev_e  = pos_prev(ear_q, n_q);
	assign next_e  = pos_next(ear_q, n_q);
	assign rev_pos = n_q - CNT_W'(1) - i_q;
	assign room    = cnt_q < CNT_W'(MAX_VERTICES);
	assign n_new   = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign ev_neg  = ev_s3[EV_W-1];
	assign ev_pos  = !ev_neg && (ev_s3 != '0);
	assign neg_f   = neg_q || ev_neg;
	assign pos_f   = pos_q || ev_pos;

	always_comb begin
		ax = sx_q[0]; ay = sy_q[0]; bx = sx_q[1]; by = sy_q[1]; qx = sx_q[2]; qy = sy_q[2];
		case (op_q)
			OP_SHO: begin
				ax = '0; ay = '0;
			end
			OP_D1: begin
				qx = sx_q[3]; qy = sy_q[3];
			end
			OP_D2: begin
				ax = sx_q[1]; ay = sy_q[1]; bx = sx_q[2]; by = sy_q[2];
				qx = sx_q[3]; qy = sy_q[3];
			end
			OP_D3: begin
				ax = sx_q[2]; ay = sy_q[2]; bx = sx_q[0]; by = sy_q[0];
				qx = sx_q[3]; qy = sy_q[3];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		bax_s1 <= DIFF_W'(bx) - DIFF_W'(ax);
		qay_s1 <= DIFF_W'(qy) - DIFF_W'(ay);
		bay_s1 <= DIFF_W'(by) - DIFF_W'(ay);
		qax_s1 <= DIFF_W'(qx) - DIFF_W'(ax);
		m1_s2  <= bax_s1 * qay_s1;
		m2_s2  <= bay_s1 * qax_s1;
		ev_s3  <= EV_W'(m1_s2) - EV_W'(m2_s2);
	end

	// In an indirect load the coordinate read address comes straight from the list read; a direct load uses the position.
	assign cm_ra = ld_dir_q ? ld_pos_q[AW-1:0] : lm_rd_q;
	assign cm_wa = cnt_q[AW-1:0];
	assign cm_wd = {x_coord, y_coord};

	// Next state and outputs. Loads and cross evaluations are shared
	// subroutines that return to the state saved in ld_ret_q or ev_ret_q.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0; out_valid = 1'b0;
		cm_we = 1'b0; lm_we = 1'b0; km_we = 1'b0;
		lm_wa = i_q[AW-1:0]; lm_wd = lm_rd_q; lm_ra = ld_pos_q[AW-1:0];
		km_wa = i_q[AW-1:0]; km_wd = CLS_COLLINEAR; km_ra = i_q[AW-1:0];
		cnt_d = cnt_q; ovf_d = ovf_q; n_d = n_q; i_d = i_q; k_d = k_q;
		ear_d = ear_q; fnr_d = fnr_q; fnr_v_d = fnr_v_q; s_d = s_q;
		neg_d = neg_q; pos_d = pos_q;
		call_ld = 1'b0; ld_pos_d = ld_pos_q; ld_slot_d = ld_slot_q;
		// A direct load keeps its mode into the cycle that reads the coordinates.
		ld_dir_d = (state_q == S_L0) ? ld_dir_q : 1'b0; ld_ret_d = ld_ret_q;
		call_ev = 1'b0; op_d = op_q; ev_ret_d = ev_ret_q; ev_cnt_d = ev_cnt_q;
		first_d = first_q; middle_d = middle_q; third_d = third_q;
		last_d = last_q; err_d = err_q; out_ret_d = out_ret_q;
		unique case (state_q)
			S_IN: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (room) begin
						cm_we = 1'b1;
						cnt_d = cnt_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (last_vertex) begin
						cnt_d = '0; ovf_d = 1'b0; n_d = n_new;
						first_d = '0; middle_d = '0; third_d = '0; last_d = 1'b1;
						out_ret_d = S_IN;
						if (ovf_q || !room) begin
							err_d = ERR_MANY; state_d = S_OUT;
						end else if (n_new < CNT_W'(3)) begin
							err_d = ERR_FEW; state_d = S_OUT;
						end else begin
							i_d = '0; s_d = '0; state_d = S_SH0;
						end
					end
				end
			end
			S_L0: state_d = S_L1;
			S_L1: state_d = S_L2;
			S_L2: state_d = ld_ret_q;
			S_EV: begin
				ev_cnt_d = ev_cnt_q + 2'd1;
				if (ev_cnt_q == 2'd2) state_d = ev_ret_q;
			end
			S_SH0: begin
				call_ld = 1'b1; ld_pos_d = i_q; ld_slot_d = 2'd1;
				ld_dir_d = 1'b1; ld_ret_d = S_SH1;
			end
			S_SH1: begin
				call_ld = 1'b1; ld_pos_d = next_i; ld_slot_d = 2'd2;
				ld_dir_d = 1'b1; ld_ret_d = S_SH2;
			end
			S_SH2: begin
				call_ev = 1'b1; op_d = OP_SHO; ev_ret_d = S_SH3;
			end
			S_SH3: begin
				s_d = s_q + SUM_W'(ev_s3);
				if (i_q == n_q - CNT_W'(1)) begin
					i_d = '0; state_d = S_IW;
				end else begin
					i_d = i_q + CNT_W'(1); state_d = S_SH0;
				end
			end
			S_IW: begin
				lm_we = 1'b1;
				lm_wd = s_d[SUM_W-1] ? i_q[AW-1:0] : rev_pos[AW-1:0];
				if (i_q == n_q - CNT_W'(1)) begin
					i_d = '0; state_d = S_CL0;
				end else begin
					i_d = i_q + CNT_W'(1);
				end
			end
			S_CL0: begin
				call_ld = 1'b1; ld_pos_d = prev_i; ld_slot_d = 2'd0; ld_ret_d = S_CL1;
			end
			S_CL1: begin
				call_ld = 1'b1; ld_pos_d = i_q; ld_slot_d = 2'd1; ld_ret_d = S_CL2;
			end
			S_CL2: begin
				call_ld = 1'b1; ld_pos_d = next_i; ld_slot_d = 2'd2; ld_ret_d = S_CL3;
			end
			S_CL3: begin
				call_ev = 1'b1; op_d = OP_TRI; ev_ret_d = S_CL4;
			end
			S_CL4: begin
				// The area term is the negated edge value, so a negative edge is convex.
				km_we = 1'b1;
				km_wd = ev_neg ? CLS_CONVEX : (ev_pos ? CLS_REFLEX : CLS_COLLINEAR);
				if (i_q == n_q - CNT_W'(1)) begin
					i_d = '0; fnr_v_d = 1'b0;
					state_d = (n_q > CNT_W'(3)) ? S_PK0 : S_FIN0;
				end else begin
					i_d = i_q + CNT_W'(1); state_d = S_CL0;
				end
			end
			S_PK0: begin
				km_ra = i_q[AW-1:0]; state_d = S_PK1;
			end
			S_PK1: begin
				if (km_rd_q == CLS_REFLEX) begin
					if (i_q == n_q - CNT_W'(1)) state_d = S_FB;
					else begin
						i_d = i_q + CNT_W'(1); state_d = S_PK0;
					end
				end else begin
					if (!fnr_v_q) begin
						fnr_d = i_q; fnr_v_d = 1'b1;
					end
					k_d = '0; state_d = S_PK2;
				end
			end
			S_PK2: begin
				call_ld = 1'b1; ld_pos_d = prev_i; ld_slot_d = 2'd0; ld_ret_d = S_PK3;
			end
			S_PK3: begin
				call_ld = 1'b1; ld_pos_d = i_q; ld_slot_d = 2'd1; ld_ret_d = S_PK4;
			end
			S_PK4: begin
				call_ld = 1'b1; ld_pos_d = next_i; ld_slot_d = 2'd2; ld_ret_d = S_KK0;
			end
			S_KK0: begin
				km_ra = k_q[AW-1:0];
				if (k_q == n_q) begin
					ear_d = i_q; state_d = S_EM0;
				end else begin
					state_d = S_KK1;
				end
			end
			S_KK1: begin
				// Only non-convex vertices off the candidate triangle can block it.
				if (k_q == i_q || k_q == prev_i || k_q == next_i ||
						km_rd_q == CLS_CONVEX) begin
					k_d = k_q + CNT_W'(1); state_d = S_KK0;
				end else begin
					call_ld = 1'b1; ld_pos_d = k_q; ld_slot_d = 2'd3; ld_ret_d = S_KK2;
				end
			end
			S_KK2: begin
				call_ev = 1'b1; op_d = OP_D1; ev_ret_d = S_KK3;
			end
			S_KK3: begin
				neg_d = ev_neg; pos_d = ev_pos;
				call_ev = 1'b1; op_d = OP_D2; ev_ret_d = S_KK4;
			end
			S_KK4: begin
				neg_d = neg_f; pos_d = pos_f;
				call_ev = 1'b1; op_d = OP_D3; ev_ret_d = S_KK5;
			end
			S_KK5: begin
				// Closed test: a point on an edge counts as inside.
				if (!(neg_f && pos_f)) begin
					if (i_q == n_q - CNT_W'(1)) state_d = S_FB;
					else begin
						i_d = i_q + CNT_W'(1); state_d = S_PK0;
					end
				end else begin
					k_d = k_q + CNT_W'(1); state_d = S_KK0;
				end
			end
			S_FB: begin
				ear_d = fnr_v_q ? fnr_q : '0; state_d = S_EM0;
			end
			S_EM0: begin
				call_ld = 1'b1; ld_pos_d = prev_e; ld_slot_d = 2'd0; ld_ret_d = S_EM1;
			end
			S_EM1: begin
				call_ld = 1'b1; ld_pos_d = ear_q; ld_slot_d = 2'd1; ld_ret_d = S_EM2;
			end
			S_EM2: begin
				call_ld = 1'b1; ld_pos_d = next_e; ld_slot_d = 2'd2; ld_ret_d = S_EM3;
			end
			S_EM3: begin
				first_d = tid_q[0]; middle_d = tid_q[1]; third_d = tid_q[2];
				last_d = 1'b0; err_d = ERR_OK; out_ret_d = S_SF0;
				i_d = ear_q; state_d = S_OUT;
			end
			S_SF0: begin
				lm_ra = next_i[AW-1:0];
				if (i_q == n_q - CNT_W'(1)) begin
					n_d = n_q - CNT_W'(1); i_d = '0; state_d = S_CL0;
				end else begin
					state_d = S_SF1;
				end
			end
			S_SF1: begin
				lm_we = 1'b1; lm_wd = lm_rd_q;
				i_d = i_q + CNT_W'(1); state_d = S_SF0;
			end
			S_FIN0: begin
				call_ld = 1'b1; ld_pos_d = CNT_W'(0); ld_slot_d = 2'd0; ld_ret_d = S_FIN1;
			end
			S_FIN1: begin
				call_ld = 1'b1; ld_pos_d = CNT_W'(1); ld_slot_d = 2'd1; ld_ret_d = S_FIN2;
			end
			S_FIN2: begin
				call_ld = 1'b1; ld_pos_d = CNT_W'(2); ld_slot_d = 2'd2; ld_ret_d = S_FIN3;
			end
			S_FIN3: begin
				first_d = tid_q[0]; middle_d = tid_q[1]; third_d = tid_q[2];
				last_d = 1'b1; err_d = ERR_OK; out_ret_d = S_IN; state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = out_ret_q;
			end
			default: state_d = S_IN;
		endcase
		if (call_ld) state_d = S_L0;
		if (call_ev) begin
			state_d = S_EV; ev_cnt_d = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN; cnt_q <= '0; ovf_q <= 1'b0; n_q <= '0;
			i_q <= '0; k_q <= '0; ear_q <= '0; fnr_q <= '0; fnr_v_q <= 1'b0;
			ld_ret_q <= S_IN; ev_ret_q <= S_IN; out_ret_q <= S_IN;
			ld_pos_q <= '0; ld_slot_q <= '0; ld_dir_q <= 1'b0;
			ev_cnt_q <= '0; op_q <= OP_TRI;
		end else begin
			state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; n_q <= n_d;
			i_q <= i_d; k_q <= k_d; ear_q <= ear_d; fnr_q <= fnr_d; fnr_v_q <= fnr_v_d;
			ld_ret_q <= ld_ret_d; ev_ret_q <= ev_ret_d; out_ret_q <= out_ret_d;
			ld_pos_q <= ld_pos_d; ld_slot_q <= ld_slot_d; ld_dir_q <= ld_dir_d;
			ev_cnt_q <= ev_cnt_d; op_q <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= s_d; neg_q <= neg_d; pos_q <= pos_d;
		first_q <= first_d; middle_q <= middle_d; third_q <= third_d;
		last_q <= last_d; err_q <= err_d;
		if (state_q == S_L1) tid_q[ld_slot_q] <= cm_ra;
		if (state_q == S_L2) begin
			sx_q[ld_slot_q] <= cm_rd_q[2*COORD_BITS-1:COORD_BITS];
			sy_q[ld_slot_q] <= cm_rd_q[COORD_BITS-1:0];
		end
	end

	assign first_index   = first_q;
	assign middle_index  = middle_q;
	assign third_index   = third_q;
	assign last_triangle = last_q;
	assign error_code    = err_q;

	// The block never takes a request while a result is on offer.
	`ECT_ASSERT(a_no_overlap, clk, arst_n, !(in_ready && out_valid))
	// The vertex count never passes the store depth.
	`ECT_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(MAX_VERTICES))
	// Any error result is the only and last result of its polygon.
	`ECT_IMPLY(a_err_last, clk, arst_n, out_valid && (error_code != ERR_OK), last_triangle)
	// While triangulating, at least a triangle remains in the list.
	`ECT_IMPLY(a_list_len, clk, arst_n, state_q != S_IN && state_q != S_OUT, n_q >= CNT_W'(3))
endmodule
`default_nettype wire
